/* hdl/dsb_pkg.sv */
// Shared types, constants, tables and rounding helpers for the detuned saw bank.
package dsb_pkg;

    localparam int NUM_SAWS    = 7;
    localparam int SAW_IW      = (NUM_SAWS > 1) ? $clog2(NUM_SAWS) : 1;

    localparam int PHASE_W     = 24;
    localparam int BASE_W      = 22;
    localparam int SPREAD_W    = 20;
    localparam int COEF_W      = 16;
    localparam int KIN_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 22;

    localparam int MUL_A_W     = 25;
    localparam int MUL_B_W     = 17;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int OFF_W       = 17;
    localparam int FRAC_SHIFT  = 15;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_STEP = CFG_IDX_W'(1);

    localparam logic [BASE_W-1:0]   BASE_STEP_RESET   = BASE_W'(19223);
    localparam logic [SPREAD_W-1:0] SPREAD_STEP_RESET = '0;

    localparam logic [KIN_W:0] Q15_ONE = (KIN_W+1)'(32768);

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(16384);
    localparam logic signed [PROD_W-1:0] SAT_MAX    = PROD_W'(8388607);
    localparam logic signed [PROD_W-1:0] SAT_MIN    = ~SAT_MAX;

    localparam logic [11:0] DETUNE_MAG [7] = '{
        12'd3605, 12'd2061, 12'd640, 12'd0, 12'd652, 12'd2037, 12'd3521
    };
    localparam logic DETUNE_NEG [7] = '{
        1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0
    };
    localparam logic [13:0] AMP_W [7] = '{
        14'd4096, 14'd2458, 14'd3277, 14'd6554, 14'd6554, 14'd3277, 14'd2458
    };

    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic [KIN_W-1:0]         kin;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic busy;
        logic out_write;
    } t_back_status;

    function automatic logic signed [PHASE_W-1:0] sat_round(
        input logic signed [PROD_W-1:0] x
    );
        logic signed [PROD_W-1:0] t;
        logic signed [PROD_W-1:0] s;
        t = x + ROUND_HALF;
        s = t >>> FRAC_SHIFT;
        if (s > SAT_MAX) begin
            s = SAT_MAX;
        end else if (s < SAT_MIN) begin
            s = SAT_MIN;
        end
        return s[PHASE_W-1:0];
    endfunction

endpackage

/* hdl/dsb_front.sv */
// Input stage: takes a coefficient, forms the 1-|c| weight and hands the job to the queue.
module dsb_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic signed [dsb_pkg::COEF_W-1:0]    i_filter_coef,
    output logic                                 o_stall,
    input  dsb_pkg::t_queue_status               i_qstat,
    output logic                                 o_push,
    output dsb_pkg::t_job                        o_job
);

    logic                              r_valid;
    dsb_pkg::t_job                     r_job;
    logic [dsb_pkg::COEF_W-1:0]        w_abs;
    logic [dsb_pkg::KIN_W:0]           w_kin;

    assign o_stall = r_valid && i_qstat.full;
    assign o_push  = r_valid && !i_qstat.full;
    assign o_job   = r_job;

    assign w_abs = i_filter_coef[dsb_pkg::COEF_W-1] ? dsb_pkg::COEF_W'(-i_filter_coef)
                                                    : dsb_pkg::COEF_W'(i_filter_coef);
    assign w_kin = dsb_pkg::Q15_ONE - {1'b0, w_abs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_job.coef <= i_filter_coef;
            r_job.kin  <= w_kin[dsb_pkg::KIN_W-1:0];
        end
    end

endmodule

/* hdl/dsb_queue.sv */
// Short job queue between the input stage and the synthesis sequencer.
module dsb_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  dsb_pkg::t_job              i_job,
    input  logic                       i_pop,
    output dsb_pkg::t_job              o_job,
    output dsb_pkg::t_queue_status     o_stat
);

    dsb_pkg::t_job                  r_mem [dsb_pkg::QUEUE_DEPTH];
    logic [dsb_pkg::QPTR_W-1:0]     r_wptr;
    logic [dsb_pkg::QPTR_W-1:0]     r_rptr;
    logic [dsb_pkg::QCNT_W-1:0]     r_count;

    assign o_stat.full  = (r_count == dsb_pkg::QCNT_W'(dsb_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_job        = r_mem[r_rptr];

    function automatic logic [dsb_pkg::QPTR_W-1:0] next_ptr(
        input logic [dsb_pkg::QPTR_W-1:0] p
    );
        if (p == dsb_pkg::QPTR_W'(dsb_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= next_ptr(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= next_ptr(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

/* hdl/dsb_back.sv */
// Sequencer: steps the saw phases through one shared multiplier, sums, filters, outputs.
module dsb_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [dsb_pkg::BASE_W-1:0]            i_base_step,
    input  logic [dsb_pkg::SPREAD_W-1:0]          i_spread_step,
    input  dsb_pkg::t_job                         i_job,
    input  dsb_pkg::t_queue_status                i_qstat,
    output logic                                  o_pop,
    output dsb_pkg::t_back_status                 o_stat,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [dsb_pkg::PHASE_W-1:0]    o_sample_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OFF  = 3'd1;
    localparam logic [2:0] S_AMP  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_F2   = 3'd4;
    localparam logic [2:0] S_F3   = 3'd5;
    localparam logic [2:0] S_F4   = 3'd6;

    logic [2:0]                                r_state;
    logic [dsb_pkg::SAW_IW-1:0]                r_idx;
    logic [dsb_pkg::PHASE_W-1:0]               r_phase [dsb_pkg::NUM_SAWS];
    logic signed [dsb_pkg::PHASE_W-1:0]        r_prev;
    logic signed [dsb_pkg::PHASE_W-1:0]        r_sum;
    logic signed [dsb_pkg::PROD_W-1:0]         r_acc;
    logic signed [dsb_pkg::PROD_W-1:0]         r_prod;
    dsb_pkg::t_job                             r_job;
    logic                                      r_out_valid;
    logic signed [dsb_pkg::PHASE_W-1:0]        r_out;

    logic signed [dsb_pkg::MUL_A_W-1:0]        w_mul_a;
    logic signed [dsb_pkg::MUL_B_W-1:0]        w_mul_b;
    logic signed [dsb_pkg::PROD_W-1:0]         w_prod;
    logic [dsb_pkg::PHASE_W-1:0]               w_phase_cur;
    logic signed [dsb_pkg::PROD_W-1:0]         w_off_sum;
    logic [dsb_pkg::PHASE_W-1:0]               w_off24;
    logic [dsb_pkg::PHASE_W-1:0]               w_base24;
    logic [dsb_pkg::PHASE_W-1:0]               w_phase_nxt;
    logic                                      w_slot_free;
    logic                                      w_out_write;
    logic                                      w_last;

    assign w_phase_cur = r_phase[r_idx];
    assign w_off_sum   = r_prod + dsb_pkg::ROUND_HALF;
    assign w_off24     = dsb_pkg::PHASE_W'(w_off_sum[dsb_pkg::FRAC_SHIFT +: dsb_pkg::OFF_W]);
    assign w_base24    = dsb_pkg::PHASE_W'(i_base_step);
    assign w_phase_nxt = dsb_pkg::DETUNE_NEG[r_idx] ? (w_phase_cur + w_base24 - w_off24)
                                                    : (w_phase_cur + w_base24 + w_off24);
    assign w_last      = (r_idx == dsb_pkg::SAW_IW'(dsb_pkg::NUM_SAWS - 1));
    assign w_slot_free = !r_out_valid || !i_stall;
    assign w_out_write = (r_state == S_F4) && w_slot_free;

    assign o_pop            = (r_state == S_IDLE) && !i_qstat.empty;
    assign o_stat.busy      = (r_state != S_IDLE);
    assign o_stat.out_write = w_out_write;
    assign o_valid          = r_out_valid;
    assign o_sample_out     = r_out;

    always_comb begin
        unique case (r_state)
            S_OFF: begin
                w_mul_a = dsb_pkg::MUL_A_W'(i_spread_step);
                w_mul_b = dsb_pkg::MUL_B_W'(dsb_pkg::DETUNE_MAG[r_idx]);
            end
            S_AMP: begin
                w_mul_a = dsb_pkg::MUL_A_W'(signed'(w_phase_cur));
                w_mul_b = dsb_pkg::MUL_B_W'(dsb_pkg::AMP_W[r_idx]);
            end
            S_F2: begin
                w_mul_a = dsb_pkg::MUL_A_W'(r_sum);
                w_mul_b = signed'({1'b0, r_job.kin});
            end
            S_F3: begin
                w_mul_a = dsb_pkg::MUL_A_W'(r_prev);
                w_mul_b = dsb_pkg::MUL_B_W'(r_job.coef);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < dsb_pkg::NUM_SAWS; k++) begin
                r_phase[k] <= '0;
            end
        end else begin
            if (w_out_write) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_idx   <= '0;
                        r_state <= S_OFF;
                    end
                end
                S_OFF: begin
                    r_state <= S_AMP;
                end
                S_AMP: begin
                    r_phase[r_idx] <= w_phase_nxt;
                    if (w_last) begin
                        r_state <= S_SUM;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_OFF;
                    end
                end
                S_SUM: begin
                    r_state <= S_F2;
                end
                S_F2: begin
                    r_state <= S_F3;
                end
                S_F3: begin
                    r_state <= S_F4;
                end
                S_F4: begin
                    if (w_slot_free) begin
                        r_prev  <= dsb_pkg::sat_round(r_acc + r_prod);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_acc <= '0;
                if (o_pop) begin
                    r_job <= i_job;
                end
            end
            S_OFF: begin
                if (r_idx != '0) begin
                    r_acc <= r_acc + r_prod;
                end
                r_prod <= w_prod;
            end
            S_AMP: begin
                r_prod <= w_prod;
            end
            S_SUM: begin
                r_sum <= dsb_pkg::sat_round(r_acc + r_prod);
            end
            S_F2: begin
                r_prod <= w_prod;
            end
            S_F3: begin
                r_acc  <= r_prod;
                r_prod <= w_prod;
            end
            S_F4: begin
                if (w_slot_free) begin
                    r_out <= dsb_pkg::sat_round(r_acc + r_prod);
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

endmodule

/* hdl/detuned_saw_bank_one_pole_unit.sv */
// Top level: configuration registers, input stage, job queue and synthesis sequencer.
//
//  channel   direction  handshake                  payload
//  input     in         i_valid / o_stall          i_filter_coef  (16, signed)
//  output    out        o_valid / i_stall          o_sample_out   (24, signed)
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index (2), i_cfg_data (22)
//
//  Each sample is worked out in turn on the shared multiplier: two products
//  per saw, then two for the filter.
//  Reset clears all saw phases and the filter history; base_step resets to 19223.
//  The input stage and a two-entry queue keep taking coefficients while the
//  sequencer works or a finished sample waits under o_valid / i_stall.
module detuned_saw_bank_one_pole_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [dsb_pkg::COEF_W-1:0]      i_filter_coef,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [dsb_pkg::PHASE_W-1:0]     o_sample_out,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [dsb_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [dsb_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    logic [dsb_pkg::BASE_W-1:0]      r_base_step;
    logic [dsb_pkg::SPREAD_W-1:0]    r_spread_step;

    logic                            w_push;
    logic                            w_pop;
    dsb_pkg::t_job                   w_front_job;
    dsb_pkg::t_job                   w_queue_job;
    dsb_pkg::t_queue_status          w_qstat;
    dsb_pkg::t_back_status           w_bstat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_step   <= dsb_pkg::BASE_STEP_RESET;
            r_spread_step <= dsb_pkg::SPREAD_STEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                dsb_pkg::REG_BASE_STEP: begin
                    r_base_step <= i_cfg_data[dsb_pkg::BASE_W-1:0];
                end
                dsb_pkg::REG_SPREAD_STEP: begin
                    r_spread_step <= i_cfg_data[dsb_pkg::SPREAD_W-1:0];
                end
                default: begin
                    r_base_step <= r_base_step;
                end
            endcase
        end
    end

    dsb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_filter_coef (i_filter_coef),
        .o_stall       (o_stall),
        .i_qstat       (w_qstat),
        .o_push        (w_push),
        .o_job         (w_front_job)
    );

    dsb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_queue_job),
        .o_stat  (w_qstat)
    );

    dsb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_base_step   (r_base_step),
        .i_spread_step (r_spread_step),
        .i_job         (w_queue_job),
        .i_qstat       (w_qstat),
        .o_pop         (w_pop),
        .o_stat        (w_bstat),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample_out  (o_sample_out)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("queue read while empty");

    a_pop_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> w_bstat.busy)
        else $error("sequencer idle after taking a job");

    a_write_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bstat.out_write |-> (!o_valid || !i_stall))
        else $error("result overwrote a stalled sample");

endmodule

/* sim/tb_detuned_saw_bank_one_pole_unit.sv */
// Self-checking testbench: predicts each filtered saw-bank sample and checks every output transfer.
module tb_detuned_saw_bank_one_pole_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 70;
    localparam int SWEEP_PHASES = 6;
    localparam longint RND_HALF = 16384;
    localparam longint UNITY    = 32768;

    localparam logic [dsb_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [dsb_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   i_valid;
    logic                                   o_stall;
    logic signed [dsb_pkg::COEF_W-1:0]      i_filter_coef;
    logic                                   o_valid;
    logic                                   i_stall;
    logic signed [dsb_pkg::PHASE_W-1:0]     o_sample_out;
    logic                                   i_cfg_valid;
    logic                                   o_cfg_ready;
    logic [dsb_pkg::CFG_IDX_W-1:0]          i_cfg_index;
    logic [dsb_pkg::CFG_DATA_W-1:0]         i_cfg_data;

    detuned_saw_bank_one_pole_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_filter_coef (i_filter_coef),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample_out  (o_sample_out),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    int saw_detune [7] = '{-3605, -2061, -640, 0, 652, 2037, 3521};
    int saw_gain   [7] = '{4096, 2458, 3277, 6554, 6554, 3277, 2458};

    logic [dsb_pkg::PHASE_W-1:0]        saw_ph [7];
    logic signed [dsb_pkg::PHASE_W-1:0] lp_hist;
    logic [dsb_pkg::BASE_W-1:0]         cur_base;
    logic [dsb_pkg::SPREAD_W-1:0]       cur_spread;

    logic signed [dsb_pkg::PHASE_W-1:0] expected_samples [$];
    logic signed [dsb_pkg::PHASE_W-1:0] want_sample;
    int  mismatches = 0;
    int  samples_seen = 0;
    int  idle_cycles = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    bit  hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint clamp24(input longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    task automatic reset_model();
        int k;
        cur_base   = dsb_pkg::BASE_STEP_RESET;
        cur_spread = '0;
        for (k = 0; k < 7; k++) saw_ph[k] = '0;
        lp_hist = '0;
    endtask

    task automatic next_sample(input logic signed [dsb_pkg::COEF_W-1:0] coef,
                               output logic signed [dsb_pkg::PHASE_W-1:0] smp);
        longint mix, off, stp, mag, sumv, absc, flt;
        int k;
        mix = 0;
        for (k = 0; k < dsb_pkg::NUM_SAWS; k++) begin
            mag = (saw_detune[k] < 0) ? -saw_detune[k] : saw_detune[k];
            off = (longint'(cur_spread) * mag + RND_HALF) >>> 15;
            stp = (saw_detune[k] < 0) ? longint'(cur_base) - off : longint'(cur_base) + off;
            mix += longint'($signed(saw_ph[k])) * saw_gain[k];
            saw_ph[k] = saw_ph[k] + stp[dsb_pkg::PHASE_W-1:0];
        end
        sumv = clamp24((mix + RND_HALF) >>> 15);
        absc = (coef < 0) ? -longint'(coef) : longint'(coef);
        flt = (UNITY - absc) * sumv + longint'(coef) * longint'(lp_hist);
        flt = clamp24((flt + RND_HALF) >>> 15);
        lp_hist = flt[dsb_pkg::PHASE_W-1:0];
        smp = flt[dsb_pkg::PHASE_W-1:0];
    endtask

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // enter and leave at a falling edge; valid stays high for a back-to-back transfer
    task automatic send_coef(input logic signed [dsb_pkg::COEF_W-1:0] coef);
        logic signed [dsb_pkg::PHASE_W-1:0] smp;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_filter_coef <= coef;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        next_sample(coef, smp);
        expected_samples.push_back(smp);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [dsb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dsb_pkg::CFG_DATA_W-1:0] data);
        i_valid <= 1'b0;
        wait (expected_samples.size() == 0);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == dsb_pkg::REG_BASE_STEP) begin
            cur_base = data[dsb_pkg::BASE_W-1:0];
        end else if (idx == dsb_pkg::REG_SPREAD_STEP) begin
            cur_spread = data[dsb_pkg::SPREAD_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        repeat (4) send_coef(16'sd0);
    endtask

    task automatic test_coef_extremes();
        send_coef(16'sd32767);
        send_coef(-16'sd32768);
        send_coef(-16'sd1);
        send_coef(16'sd1);
        send_coef(16'sd16384);
        send_coef(-16'sd16384);
    endtask

    task automatic test_register_writes();
        write_reg(dsb_pkg::REG_BASE_STEP, 22'h3FFFFF);
        write_reg(dsb_pkg::REG_SPREAD_STEP, 22'h3FFFFF);
        write_reg(REG_UNUSED_2, 22'($urandom));
        write_reg(REG_UNUSED_3, 22'($urandom));
        send_coef(16'sd0);
        send_coef(-16'sd32768);
        send_coef(16'sd32767);
        send_coef(16'sd0);
    endtask

    task automatic test_downward_saw();
        write_reg(dsb_pkg::REG_BASE_STEP, 22'd100);
        write_reg(dsb_pkg::REG_SPREAD_STEP, 22'h0FFFFF);
        send_coef(16'sd0);
        send_coef(16'sd0);
        send_coef(16'sd12000);
        send_coef(-16'sd32768);
        write_reg(dsb_pkg::REG_BASE_STEP, 22'd0);
        write_reg(dsb_pkg::REG_SPREAD_STEP, 22'd0);
        send_coef(16'sd0);
        send_coef(-16'sd20000);
    endtask

    task automatic test_backpressure();
        int n;
        tx_idle_on = 1'b0;
        hold_req = 1'b1;
        for (n = 0; n < 12; n++) send_coef(16'($urandom));
        wait (!hold_req);
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_sweep();
        logic [dsb_pkg::CFG_DATA_W-1:0] b, s;
        logic signed [dsb_pkg::COEF_W-1:0] c;
        int ph, n;
        for (ph = 0; ph < SWEEP_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0: b = '0;
                1: b = 22'h3FFFFF;
                2: b = 22'($urandom_range(0, 4000));
                default: b = 22'($urandom);
            endcase
            case ($urandom_range(0, 2))
                0: s = '0;
                1: s = 22'h3FFFFF;
                default: s = 22'($urandom);
            endcase
            if ($urandom_range(0, 1) == 0) begin
                write_reg(dsb_pkg::REG_BASE_STEP, b);
                write_reg(dsb_pkg::REG_SPREAD_STEP, s);
            end else begin
                write_reg(dsb_pkg::REG_SPREAD_STEP, s);
                write_reg(dsb_pkg::REG_BASE_STEP, b);
            end
            if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED_2, 22'($urandom));
            if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED_3, 22'($urandom));
            if (ph == SWEEP_PHASES - 1) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 11))
                    0: c = -16'sd32768;
                    1: c = 16'sd32767;
                    2: c = 16'sd0;
                    default: c = 16'($urandom);
                endcase
                send_coef(c);
            end
        end
    endtask

    initial begin : rx_pacing
        int hold_cnt;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge i_clk);
                i_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            samples_seen++;
            if (expected_samples.size() == 0) begin
                flag_mismatch($sformatf("sample %0d: unexpected value %0d",
                                        samples_seen, o_sample_out));
            end else begin
                want_sample = expected_samples.pop_front();
                if (o_sample_out !== want_sample) begin
                    flag_mismatch($sformatf("sample %0d: sample_out %0d, want %0d",
                                            samples_seen, o_sample_out, want_sample));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_filter_coef = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        reset_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_coef_extremes();
        test_register_writes();
        test_downward_saw();
        test_backpressure();
        test_random_sweep();

        i_valid <= 1'b0;
        wait (expected_samples.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* detuned_saw_bank_one_pole_unit.f */
hdl/dsb_pkg.sv
hdl/dsb_front.sv
hdl/dsb_queue.sv
hdl/dsb_back.sv
hdl/detuned_saw_bank_one_pole_unit.sv
sim/tb_detuned_saw_bank_one_pole_unit.sv
